// ----- hdl/ccma_pkg.sv -----
// ----------------------------------------------------------------------------
// ccma_pkg: shared types and constants for the calendar clock minute adder
// transaction structs, operation codes, reset values and the month length table
// ----------------------------------------------------------------------------
package ccma_pkg;

  localparam int VALUE_WIDTH       = 16;
  localparam int ADD_WIDTH_DEFAULT = 16;

  localparam int MINUTES_PER_HOUR = 60;
  localparam int HOURS_PER_DAY    = 24;
  localparam int MONTHS_PER_YEAR  = 12;

  localparam logic [5:0]  MINUTE_RESET  = 6'd59;
  localparam logic [4:0]  HOUR_RESET    = 5'd23;
  localparam logic [4:0]  DAY_RESET     = 5'd31;
  localparam logic [3:0]  MONTH_RESET   = 4'd12;
  localparam logic [15:0] YEAR_RESET    = 16'd9999;
  localparam logic [2:0]  WEEKDAY_RESET = 3'd7;

  typedef enum logic [2:0] {
    OP_ADD_MINUTES = 3'd0,
    OP_SET_YEAR    = 3'd1,
    OP_SET_MONTH   = 3'd2,
    OP_SET_DAY     = 3'd3,
    OP_SET_HOURS   = 3'd4,
    OP_SET_MINUTES = 3'd5,
    OP_SET_WEEKDAY = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]             operation;
    logic [VALUE_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic        error;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic [2:0]  weekday_out;
  } rsp_t;

  // fixed month lengths, february at 28 days, unused codes read as 31
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/calendar_clock_minute_adder.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_minute_adder: calendar time keeper with a minute adder
// holds minute, hour, day, month, year and weekday; adds minutes or sets a field
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req) carries one operation and a
//   16-bit value; rsp channel (rsp_valid / rsp_stall / rsp) returns one
//   transaction per request: an error flag and the whole time afterwards
//   set operations: the response is valid the cycle after the request is
//   taken, so set transactions can follow every cycle while rsp_stall is low
//   an add of minutes runs on one shared reciprocal multiplier and one shared
//   compare-subtract unit: a multiply then a subtract split minutes from
//   hours, the same pair splits hours from days, then one step per month
//   crossed plus one; one add crosses at most two month ends
//   one request is in flight at a time; req_stall is high while an add runs
//   and while an earlier response is held by rsp_stall
//   a stalled response stays in the output register unchanged
//   synchronous reset sets 23:59 on 31.12.9999, sunday, and empties the
//   response register
// ----------------------------------------------------------------------------
module calendar_clock_minute_adder #(
  parameter int ADD_WIDTH = ccma_pkg::ADD_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ccma_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ccma_pkg::rsp_t rsp
);

  // only the value's low bits take part, and the value is 16 bits wide
  localparam int AW = (ADD_WIDTH < ccma_pkg::VALUE_WIDTH) ? ADD_WIDTH
                                                         : ccma_pkg::VALUE_WIDTH;
  // minute plus addend, also wide enough for hour plus quotient and day sum
  localparam int TW = AW + 1;

  // quotient by reciprocal, exact for every dividend below 2**DIV_BITS
  localparam int DIV_BITS    = ccma_pkg::VALUE_WIDTH + 1;
  localparam int RECIP_SHIFT = DIV_BITS + 6;
  localparam int RECIP_BITS  = 19;
  localparam int PW          = DIV_BITS + RECIP_BITS;
  localparam int RECIP_MIN   = ((1 << RECIP_SHIFT) + ccma_pkg::MINUTES_PER_HOUR - 1)
                               / ccma_pkg::MINUTES_PER_HOUR;
  localparam int RECIP_HOUR  = ((1 << RECIP_SHIFT) + ccma_pkg::HOURS_PER_DAY - 1)
                               / ccma_pkg::HOURS_PER_DAY;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN_DIV,
    S_MIN_REM,
    S_HOUR_DIV,
    S_HOUR_REM,
    S_DAY_CARRY
  } state_t;

  state_t state, state_next;

  // time registers
  logic [5:0]  minute_count, minute_next;
  logic [4:0]  hour_count, hour_next;
  logic [4:0]  day_count, day_next;
  logic [3:0]  month_count, month_next;
  logic [15:0] year_count, year_next;
  logic [2:0]  weekday_value, weekday_next;

  // sequencer datapath: dividend or day sum, and the held quotient
  logic [TW-1:0] acc, acc_next;
  logic [TW-1:0] quo, quo_next;

  logic           err_next;
  logic           load_rsp;
  logic           accept;
  logic [AW-1:0]  addend;
  logic [4:0]     cur_len;

  // shared reciprocal multiplier
  logic [DIV_BITS-1:0]   mul_a;
  logic [RECIP_BITS-1:0] mul_b;
  logic [PW-1:0]         prod;
  logic [TW-1:0]         div_q;

  // shared compare-subtract unit
  logic [TW-1:0] sub_a, sub_b;
  logic [TW:0]   sub_res;
  logic          borrow;
  logic          day_over;

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign addend    = req.value[AW-1:0];
  assign cur_len   = ccma_pkg::month_len(month_count);

  always_comb begin
    mul_b = RECIP_BITS'(RECIP_MIN);
    sub_b = TW'(cur_len);
    case (state)
      S_HOUR_DIV: begin
        mul_b = RECIP_BITS'(RECIP_HOUR);
      end
      S_MIN_REM: begin
        sub_b = quo * TW'(ccma_pkg::MINUTES_PER_HOUR);
      end
      S_HOUR_REM: begin
        sub_b = quo * TW'(ccma_pkg::HOURS_PER_DAY);
      end
      default: begin
      end
    endcase
  end

  assign mul_a = DIV_BITS'(acc);
  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign div_q = TW'(prod[PW-1:RECIP_SHIFT]);

  assign sub_a    = acc;
  assign sub_res  = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_res[TW];
  // day beyond month end: days - len is positive
  assign day_over = !borrow && (sub_res[TW-1:0] != '0);

  always_comb begin
    state_next   = state;
    minute_next  = minute_count;
    hour_next    = hour_count;
    day_next     = day_count;
    month_next   = month_count;
    year_next    = year_count;
    weekday_next = weekday_value;
    acc_next     = acc;
    quo_next     = quo;
    err_next     = 1'b1;
    load_rsp     = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          load_rsp = 1'b1;
          case (req.operation)
            ccma_pkg::OP_ADD_MINUTES: begin
              if (addend != '0) begin
                // response comes when the carries are done
                load_rsp   = 1'b0;
                acc_next   = TW'(minute_count) + TW'(addend);
                state_next = S_MIN_DIV;
              end
            end
            ccma_pkg::OP_SET_YEAR: begin
              year_next = req.value;
              err_next  = 1'b0;
            end
            ccma_pkg::OP_SET_MONTH: begin
              if (req.value inside {[1:ccma_pkg::MONTHS_PER_YEAR]}) begin
                month_next = req.value[3:0];
                err_next   = 1'b0;
              end
            end
            ccma_pkg::OP_SET_DAY: begin
              if ((req.value != '0) && (req.value <= 16'(cur_len))) begin
                day_next = req.value[4:0];
                err_next = 1'b0;
              end
            end
            ccma_pkg::OP_SET_HOURS: begin
              if (req.value inside {[0:ccma_pkg::HOURS_PER_DAY-1]}) begin
                hour_next = req.value[4:0];
                err_next  = 1'b0;
              end
            end
            ccma_pkg::OP_SET_MINUTES: begin
              if (req.value inside {[0:ccma_pkg::MINUTES_PER_HOUR-1]}) begin
                minute_next = req.value[5:0];
                err_next    = 1'b0;
              end
            end
            ccma_pkg::OP_SET_WEEKDAY: begin
              if (req.value inside {[1:7]}) begin
                weekday_next = req.value[2:0];
                err_next     = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MIN_DIV, S_HOUR_DIV: begin
        // quotient from the reciprocal product
        quo_next   = div_q;
        state_next = (state == S_MIN_DIV) ? S_MIN_REM : S_HOUR_REM;
      end

      S_MIN_REM: begin
        // remainder is the new minute, quotient carries into the hour
        minute_next = sub_res[5:0];
        acc_next    = TW'(hour_count) + quo;
        state_next  = S_HOUR_DIV;
      end

      S_HOUR_REM: begin
        hour_next  = sub_res[4:0];
        acc_next   = TW'(day_count) + quo;
        state_next = S_DAY_CARRY;
      end

      S_DAY_CARRY: begin
        if (day_over) begin
          // step over one month end
          acc_next = sub_res[TW-1:0];
          if (month_count >= 4'(ccma_pkg::MONTHS_PER_YEAR)) begin
            month_next = 4'd1;
            year_next  = year_count + 16'd1;
          end else begin
            month_next = month_count + 4'd1;
          end
        end else begin
          day_next   = acc[4:0];
          err_next   = 1'b0;
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      minute_count  <= ccma_pkg::MINUTE_RESET;
      hour_count    <= ccma_pkg::HOUR_RESET;
      day_count     <= ccma_pkg::DAY_RESET;
      month_count   <= ccma_pkg::MONTH_RESET;
      year_count    <= ccma_pkg::YEAR_RESET;
      weekday_value <= ccma_pkg::WEEKDAY_RESET;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      minute_count  <= minute_next;
      hour_count    <= hour_next;
      day_count     <= day_next;
      month_count   <= month_next;
      year_count    <= year_next;
      weekday_value <= weekday_next;
      // a new response only loads into a free or emptying slot
      rsp_valid     <= load_rsp || (rsp_valid && rsp_stall);
    end
    acc <= acc_next;
    quo <= quo_next;
    if (load_rsp) begin
      rsp.error       <= err_next;
      rsp.minute_out  <= minute_next;
      rsp.hour_out    <= hour_next;
      rsp.day_out     <= day_next;
      rsp.month_out   <= month_next;
      rsp.year_out    <= year_next;
      rsp.weekday_out <= weekday_next;
    end
  end

endmodule
